>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/momt_pkg.sv
// Shared types and op codes of the move-op merge translator.
package momt_pkg;

    typedef enum logic [3:0] {
        KIND_CAPLEN  = 4'd0,
        KIND_CAPCHR  = 4'd1,
        KIND_CAPEND  = 4'd2,
        KIND_MATCH   = 4'd3,
        KIND_JUMPABS = 4'd4,
        KIND_JUMPEND = 4'd5,
        KIND_FWD     = 4'd6,
        KIND_BACK    = 4'd7,
        KIND_FINDFWD = 4'd8,
        KIND_FINDREV = 4'd9
    } kind_t;

    // On the result side code 3 means "skip by length".
    localparam kind_t KIND_SKIP = KIND_MATCH;

    localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } phase_t;

    // One pass-through op, already in result form.
    typedef struct packed {
        kind_t       kind;
        logic [30:0] amount;
        logic [7:0]  chr;
        logic        from_end;
    } op_t;

    // Queue entry: optional run flush followed by optional op.
    typedef struct packed {
        logic        flush_open;
        logic        flush_skip;
        logic        op_vld;
        op_t         op;
        logic [15:0] param_total;
    } ent_t;

endpackage

>>> hw/rtl/momt_front.sv
// Front end: accepts requests, merges move runs, builds queue entries.
module momt_front #(
    parameter int AMOUNT_WIDTH = 16,
    parameter int SUM_WIDTH    = 32,
    parameter int COUNT_WIDTH  = 16,
    parameter int RUN_WIDTH    = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [3:0]            req_type,
    input  logic [15:0]           amount,
    input  logic [7:0]            target_char,
    input  logic                  from_end,
    input  logic                  list_end,
    input  logic                  q_full,
    output logic                  push,
    output momt_pkg::ent_t        ent,
    output logic [RUN_WIDTH-1:0]  flush_sum
);
    import momt_pkg::*;

    localparam int AMT_BITS = (AMOUNT_WIDTH < 16) ? AMOUNT_WIDTH : 16;
    localparam int ADD_W    = RUN_WIDTH + 1;
    localparam int PAD_W    = ADD_W - SUM_WIDTH + 1;
    localparam logic signed [ADD_W-1:0] SMAX = {{PAD_W{1'b0}}, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [ADD_W-1:0] SMIN = {{PAD_W{1'b1}}, {(SUM_WIDTH-1){1'b0}}};

    logic                   run_open_reg, run_open_next;
    logic [RUN_WIDTH-1:0]   run_sum_reg, run_sum_next;
    logic                   run_skip_reg, run_skip_next;
    logic [COUNT_WIDTH-1:0] cap_reg, cap_next;

    logic                   accept;
    logic                   is_match, is_back, is_move, is_pass, is_cap;
    logic [AMT_BITS-1:0]    amt;
    logic signed [ADD_W-1:0] mv_mag, mv, run_ext, add_sum, sat_sum;
    logic [RUN_WIDTH-1:0]   new_sum;
    logic                   new_skip;

    assign req_ready = !q_full;
    assign accept    = req_valid && req_ready;

    assign is_match = (req_type == KIND_MATCH);
    assign is_back  = (req_type == KIND_BACK);
    assign is_move  = is_match || is_back || (req_type == KIND_FWD);
    assign is_pass  = (req_type <= KIND_FINDREV) && !is_move;
    assign is_cap   = (req_type <= KIND_CAPEND);

    assign amt     = amount[AMT_BITS-1:0];
    assign mv_mag  = {{(ADD_W-AMT_BITS){1'b0}}, amt};
    assign mv      = is_back ? -mv_mag : mv_mag;
    assign run_ext = {run_sum_reg[RUN_WIDTH-1], run_sum_reg};
    assign add_sum = run_ext + mv;

    // Clamp the running sum to the signed SUM_WIDTH range
    always_comb
    begin
        if (add_sum > SMAX)
        begin
            sat_sum = SMAX;
        end
        else if (add_sum < SMIN)
        begin
            sat_sum = SMIN;
        end
        else
        begin
            sat_sum = add_sum;
        end
    end

    // First move of a run loads unclamped, as the run starts fresh
    assign new_sum  = run_open_reg ? sat_sum[RUN_WIDTH-1:0] : mv[RUN_WIDTH-1:0];
    assign new_skip = run_open_reg ? (run_skip_reg || is_match) : is_match;

    assign cap_next = (is_cap && (cap_reg != {COUNT_WIDTH{1'b1}})) ? cap_reg + 1'b1 : cap_reg;

    always_comb
    begin
        run_open_next = run_open_reg;
        run_sum_next  = run_sum_reg;
        run_skip_next = run_skip_reg;
        if (is_move && !list_end)
        begin
            run_open_next = 1'b1;
            run_sum_next  = new_sum;
            run_skip_next = new_skip;
        end
        else if (is_move || is_pass || list_end)
        begin
            run_open_next = 1'b0;
            run_sum_next  = '0;
            run_skip_next = 1'b0;
        end
    end

    // Entry build
    always_comb
    begin
        ent = '0;
        if (is_move && list_end)
        begin
            ent.flush_open = 1'b1;
            ent.flush_skip = new_skip;
            flush_sum      = new_sum;
        end
        else
        begin
            ent.flush_open = run_open_reg && (is_pass || (!is_move && list_end));
            ent.flush_skip = run_skip_reg;
            flush_sum      = run_sum_reg;
        end
        ent.op_vld      = is_pass;
        ent.op.kind     = is_pass ? kind_t'(req_type) : KIND_CAPLEN;
        ent.op.amount   = ((req_type == KIND_CAPLEN) || (req_type == KIND_JUMPABS)
                          || (req_type == KIND_JUMPEND)) ? 31'(amt) : '0;
        ent.op.chr      = ((req_type == KIND_CAPCHR) || (req_type == KIND_FINDFWD)
                          || (req_type == KIND_FINDREV)) ? target_char : '0;
        ent.op.from_end = (req_type == KIND_JUMPEND) ? from_end : 1'b0;
        ent.param_total = 16'(cap_next);
    end

    assign push = accept && (ent.flush_open || ent.op_vld);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg <= 1'b0;
            run_sum_reg  <= '0;
            run_skip_reg <= 1'b0;
            cap_reg      <= '0;
        end
        else if (accept)
        begin
            run_open_reg <= run_open_next;
            run_sum_reg  <= run_sum_next;
            run_skip_reg <= run_skip_next;
            cap_reg      <= cap_next;
        end
    end

endmodule

>>> hw/rtl/momt_queue.sv
// Small flip-flop FIFO between front and back end.
module momt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == (PW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

endmodule

>>> hw/rtl/momt_back.sv
// Back end: turns queue entries into results through an output register.
module momt_back #(
    parameter int RUN_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  momt_pkg::ent_t       ent,
    input  logic [RUN_WIDTH-1:0] flush_sum,
    output logic                 pop,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [3:0]           out_kind,
    output logic [30:0]          out_amount,
    output logic [7:0]           out_char,
    output logic                 out_from_end,
    output logic [15:0]          out_index,
    output logic [15:0]          param_total,
    output logic                 run_last
);
    import momt_pkg::*;

    localparam int MW = RUN_WIDTH + 1;
    localparam int CW = (MW > 32) ? MW : 32;

    phase_t      phase_reg, phase_next;
    logic        valid_reg, valid_next;
    logic [15:0] idx_reg;
    kind_t       kind_reg, kind_next;
    logic [30:0] amount_reg, amount_next;
    logic [7:0]  char_reg, char_next;
    logic        fe_reg, fe_next;
    logic [15:0] index_reg;
    logic [15:0] ptot_reg;
    logic        last_reg, last_next;

    logic          load, have, flush_emit, emit;
    logic          neg;
    logic [MW-1:0] sum_ext, mag;
    logic [CW-1:0] mag_w;
    logic [30:0]   mag_sat;
    kind_t         flush_kind;

    assign load       = !valid_reg || rsp_ready;
    assign have       = load && !empty;
    assign flush_emit = ent.flush_open && (flush_sum != '0) && (phase_reg == PH_FIRST);

    // Flush result: magnitude and direction of the merged run
    assign neg        = flush_sum[RUN_WIDTH-1];
    assign sum_ext    = {flush_sum[RUN_WIDTH-1], flush_sum};
    assign mag        = neg ? -sum_ext : sum_ext;
    assign mag_w      = CW'(mag);
    assign mag_sat    = (mag_w > CW'(MAG_MAX)) ? MAG_MAX : mag_w[30:0];
    assign flush_kind = neg ? KIND_BACK : (ent.flush_skip ? KIND_SKIP : KIND_FWD);

    // Next state: second phase only while a flush waits on its op
    always_comb
    begin
        phase_next = phase_reg;
        if (have)
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    if (flush_emit && ent.op_vld)
                    begin
                        phase_next = PH_SECOND;
                    end
                end
                PH_SECOND:
                begin
                    phase_next = PH_FIRST;
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    // Outputs of the sequencer
    always_comb
    begin
        pop         = 1'b0;
        emit        = 1'b0;
        kind_next   = ent.op.kind;
        amount_next = ent.op.amount;
        char_next   = ent.op.chr;
        fe_next     = ent.op.from_end;
        last_next   = 1'b1;
        if (have)
        begin
            if (flush_emit)
            begin
                emit        = 1'b1;
                kind_next   = flush_kind;
                amount_next = mag_sat;
                char_next   = '0;
                fe_next     = 1'b0;
                last_next   = !ent.op_vld;
                pop         = !ent.op_vld;
            end
            else
            begin
                pop  = 1'b1;
                emit = ent.op_vld;
            end
        end
    end

    assign valid_next = load ? emit : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
            if (load && emit)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && emit)
        begin
            kind_reg   <= kind_next;
            amount_reg <= amount_next;
            char_reg   <= char_next;
            fe_reg     <= fe_next;
            index_reg  <= idx_reg;
            ptot_reg   <= ent.param_total;
            last_reg   <= last_next;
        end
    end

    assign rsp_valid    = valid_reg;
    assign out_kind     = kind_reg;
    assign out_amount   = amount_reg;
    assign out_char     = char_reg;
    assign out_from_end = fe_reg;
    assign out_index    = index_reg;
    assign param_total  = ptot_reg;
    assign run_last     = last_reg;

endmodule

>>> hw/rtl/move_op_merge_translator.sv
// Top level of the move-op merge translator: front end, entry queue, back end.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------------
//  request  | req_valid / req_ready | req_type, amount, target_char, from_end,
//           |                       | list_end
//  result   | rsp_valid / rsp_ready | out_kind, out_amount, out_char, out_from_end,
//           |                       | out_index, param_total, run_last
//
//  One request is taken per cycle while the entry queue has room; the front end
//  does one saturating add of the run sum per request.
//  The back end drains one result per cycle through its output register unless
//  rsp_ready stalls it; a request with a non-zero flush and an op makes two results.
//  Requests that only extend a run produce no queue entry at all.
//  A request's first result passes the entry queue and then the output register.
//  Asynchronous active-low reset closes any run and clears the counters and the
//  queue; no clearing pass is needed.
module move_op_merge_translator #(
    parameter int AMOUNT_WIDTH = 16,
    parameter int SUM_WIDTH    = 32,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [3:0]  req_type,
    input  logic [15:0] amount,
    input  logic [7:0]  target_char,
    input  logic        from_end,
    input  logic        list_end,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [3:0]  out_kind,
    output logic [30:0] out_amount,
    output logic [7:0]  out_char,
    output logic        out_from_end,
    output logic [15:0] out_index,
    output logic [15:0] param_total,
    output logic        run_last
);
    import momt_pkg::*;

    localparam int AMT_BITS    = (AMOUNT_WIDTH < 16) ? AMOUNT_WIDTH : 16;
    // Run sum is wide enough for the clamped range and for one raw move
    localparam int RUN_WIDTH   = (SUM_WIDTH > AMT_BITS) ? SUM_WIDTH : AMT_BITS + 1;
    localparam int ENT_W       = $bits(ent_t);
    localparam int QW          = RUN_WIDTH + ENT_W;
    localparam int QUEUE_DEPTH = 4;

    ent_t                 f_ent, b_ent;
    logic [RUN_WIDTH-1:0] f_sum, b_sum;
    logic                 q_push, q_full, q_pop, q_empty;
    logic [QW-1:0]        q_dout;

    momt_front #(
        .AMOUNT_WIDTH (AMOUNT_WIDTH),
        .SUM_WIDTH    (SUM_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .RUN_WIDTH    (RUN_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .amount      (amount),
        .target_char (target_char),
        .from_end    (from_end),
        .list_end    (list_end),
        .q_full      (q_full),
        .push        (q_push),
        .ent         (f_ent),
        .flush_sum   (f_sum)
    );

    momt_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   ({f_sum, f_ent}),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    assign b_sum = q_dout[QW-1:ENT_W];
    assign b_ent = ent_t'(q_dout[ENT_W-1:0]);

    momt_back #(
        .RUN_WIDTH (RUN_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (q_empty),
        .ent          (b_ent),
        .flush_sum    (b_sum),
        .pop          (q_pop),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .out_kind     (out_kind),
        .out_amount   (out_amount),
        .out_char     (out_char),
        .out_from_end (out_from_end),
        .out_index    (out_index),
        .param_total  (param_total),
        .run_last     (run_last)
    );

endmodule

>>> hw/rtl/momt_checker.sv
// Port-level checker for the translator, bound to the top level.
`include "assert_macros.svh"

module momt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [3:0]  out_kind,
    input logic [30:0] out_amount,
    input logic [15:0] out_index,
    input logic [15:0] param_total,
    input logic        run_last
);
    import momt_pkg::*;

    // A stalled result holds
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(out_amount) && $stable(out_index))

    // Never a kind code beyond the defined kinds
    `ASSERT_IMPLY(a_kind_range, clk, rst_n, rsp_valid, out_kind <= KIND_FINDREV)

    // The second result of a request follows at once
    `ASSERT_NEXT(a_pair_follows, clk, rst_n, rsp_valid && rsp_ready && !run_last, rsp_valid && (out_index == $past(out_index) + 16'd1))

    // Both results of a request carry the same capture count
    `ASSERT_NEXT(a_pair_ptotal, clk, rst_n, rsp_valid && rsp_ready && !run_last, param_total == $past(param_total))

endmodule

bind move_op_merge_translator momt_checker u_momt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .out_kind    (out_kind),
    .out_amount  (out_amount),
    .out_index   (out_index),
    .param_total (param_total),
    .run_last    (run_last)
);
